/* rtl/core/sts_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and bus packing helpers for the sphere triangle subdivider
// no dependencies

package sts_pkg;

    localparam int CW            = 16;
    localparam int DEPTH_W       = 2;
    localparam int TRI_W         = 9 * CW;
    localparam int MAX_DEPTH_DEF = 3;
    localparam int FRAC_BITS_DEF = 14;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } sts_vertex_t;

    typedef struct packed {
        sts_vertex_t a;
        sts_vertex_t b;
        sts_vertex_t c;
    } sts_tgl_t;

    typedef struct packed {
        logic                valid;
        sts_tgl_t            tgl;
        logic [DEPTH_W-1:0]  depth;
    } sts_job_t;

    typedef struct packed {
        logic        done;
        logic        zero;
        sts_vertex_t r;
    } sts_norm_res_t;

    function automatic sts_tgl_t tgl_from_bus(input logic [TRI_W-1:0] d);
        sts_tgl_t t;
        t.a.x = d[0*CW +: CW];
        t.a.y = d[1*CW +: CW];
        t.a.z = d[2*CW +: CW];
        t.b.x = d[3*CW +: CW];
        t.b.y = d[4*CW +: CW];
        t.b.z = d[5*CW +: CW];
        t.c.x = d[6*CW +: CW];
        t.c.y = d[7*CW +: CW];
        t.c.z = d[8*CW +: CW];
        return t;
    endfunction

    function automatic logic [TRI_W-1:0] tgl_to_bus(input sts_tgl_t t);
        logic [TRI_W-1:0] d;
        d[0*CW +: CW] = t.a.x;
        d[1*CW +: CW] = t.a.y;
        d[2*CW +: CW] = t.a.z;
        d[3*CW +: CW] = t.b.x;
        d[4*CW +: CW] = t.b.y;
        d[5*CW +: CW] = t.b.z;
        d[6*CW +: CW] = t.c.x;
        d[7*CW +: CW] = t.c.y;
        d[8*CW +: CW] = t.c.z;
        return d;
    endfunction

endpackage

/* rtl/core/sts_front.sv */
`timescale 1ns / 1ps
// front end: depth register, input beat capture, depth clamp and two-entry job queue
// depends on sts_pkg

module sts_front #(
    parameter int MAX_DEPTH = sts_pkg::MAX_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [sts_pkg::DEPTH_W-1:0] cfg_wdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [sts_pkg::TRI_W-1:0]   s_tdata,
    output sts_pkg::sts_job_t           job,
    input  logic                        job_ready
);
    import sts_pkg::*;

    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] depth_eff;
    sts_tgl_t           q_tgl_reg [2];
    logic [DEPTH_W-1:0] q_dep_reg [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         cnt_reg;
    logic [1:0]         cnt_next;
    logic               push;
    logic               pop;

    assign depth_eff = (int'(depth_reg) > MAX_DEPTH) ? DEPTH_W'(MAX_DEPTH) : depth_reg;
    assign s_tready  = (cnt_reg != 2'd2);
    assign push      = s_tvalid && s_tready;
    assign pop       = job.valid && job_ready;

    assign job.valid = (cnt_reg != 2'd0);
    assign job.tgl   = q_tgl_reg[rd_ptr_reg];
    assign job.depth = q_dep_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                depth_reg <= cfg_wdata;
            end
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_tgl_reg[wr_ptr_reg] <= tgl_from_bus(s_tdata);
            q_dep_reg[wr_ptr_reg] <= depth_eff;
        end
    end

endmodule

/* rtl/core/sts_norm.sv */
`timescale 1ns / 1ps
// midpoint normalizer: sum of squares, bit-serial square root, restoring divide per axis
// depends on sts_pkg

module sts_norm #(
    parameter int FRAC_BITS = sts_pkg::FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  sts_pkg::sts_vertex_t  p,
    input  sts_pkg::sts_vertex_t  q,
    output sts_pkg::sts_norm_res_t res
);
    import sts_pkg::*;

    localparam int MW  = CW + 1;
    localparam int SW  = 2 * MW;
    localparam int XW  = SW + 16;
    localparam int RW  = XW / 2;
    localparam int DW  = RW + 1;
    localparam int QW  = FRAC_BITS + 2;
    localparam int NW  = MW + FRAC_BITS + 10;
    localparam int CNW = $clog2(RW + 1);
    localparam int LIM = ((1 << FRAC_BITS) < 32767) ? (1 << FRAC_BITS) : 32767;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQ   = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_ROOT = 3'd3;
    localparam logic [2:0] S_DSET = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0]             st_reg;
    logic signed [MW-1:0]   mx_reg, my_reg, mz_reg;
    logic signed [MW-1:0]   m_sel;
    logic [MW-1:0]          a_sel;
    logic [SW-1:0]          prod_reg;
    logic [SW-1:0]          s_reg;
    logic [XW-1:0]          x_reg, rt_reg, bit_reg;
    logic [XW-1:0]          rt_sum;
    logic [CNW-1:0]         cnt_reg;
    logic [1:0]             i_reg;
    logic [QW-1:0]          low_reg;
    logic [DW:0]            rem_reg;
    logic [QW-1:0]          quo_reg;
    logic                   ovf_reg;
    logic [DW-1:0]          dval;
    logic [NW-1:0]          nval;
    logic [DW:0]            trial;
    logic [QW-1:0]          vq;
    logic [CW-1:0]          vc;
    sts_vertex_t            r_reg;
    logic                   zero_reg;
    logic                   done_reg;

    always_comb
    begin
        case (i_reg)
            2'd0:    m_sel = mx_reg;
            2'd1:    m_sel = my_reg;
            default: m_sel = mz_reg;
        endcase
    end

    assign a_sel  = m_sel[MW-1] ? MW'(-m_sel) : MW'(m_sel);
    assign rt_sum = rt_reg + bit_reg;
    assign dval   = {rt_reg[RW-1:0], 1'b0};
    assign nval   = (NW'(a_sel) << (FRAC_BITS + 9)) + NW'(rt_reg[RW-1:0]);
    assign trial  = {rem_reg[DW-1:0], low_reg[QW-1]};
    assign vq     = (ovf_reg || (quo_reg > QW'(LIM))) ? QW'(LIM) : quo_reg;
    assign vc     = CW'(vq);

    assign res.done = done_reg;
    assign res.zero = zero_reg;
    assign res.r    = r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            i_reg    <= 2'd0;
        end
        else
        begin
            case (st_reg)
                S_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        cnt_reg <= '0;
                        i_reg   <= 2'd0;
                        st_reg  <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (i_reg != 2'd2)
                    begin
                        i_reg <= i_reg + 2'd1;
                    end
                    if (cnt_reg == CNW'(3))
                    begin
                        st_reg <= S_CHK;
                    end
                end
                S_CHK:
                begin
                    cnt_reg <= '0;
                    if (s_reg == '0)
                    begin
                        done_reg <= 1'b1;
                        st_reg   <= S_IDLE;
                    end
                    else
                    begin
                        st_reg <= S_ROOT;
                    end
                end
                S_ROOT:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNW'(RW - 1))
                    begin
                        i_reg  <= 2'd0;
                        st_reg <= S_DSET;
                    end
                end
                S_DSET:
                begin
                    cnt_reg <= '0;
                    st_reg  <= S_DIV;
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNW'(QW - 1))
                    begin
                        st_reg <= S_FIN;
                    end
                end
                S_FIN:
                begin
                    if (i_reg == 2'd2)
                    begin
                        done_reg <= 1'b1;
                        st_reg   <= S_IDLE;
                    end
                    else
                    begin
                        i_reg  <= i_reg + 2'd1;
                        st_reg <= S_DSET;
                    end
                end
                default:
                begin
                    st_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            S_IDLE:
            begin
                mx_reg   <= MW'(p.x) + MW'(q.x);
                my_reg   <= MW'(p.y) + MW'(q.y);
                mz_reg   <= MW'(p.z) + MW'(q.z);
                s_reg    <= '0;
                zero_reg <= 1'b0;
            end
            S_SQ:
            begin
                prod_reg <= SW'(a_sel) * SW'(a_sel);
                if (cnt_reg != '0)
                begin
                    s_reg <= s_reg + prod_reg;
                end
            end
            S_CHK:
            begin
                x_reg   <= XW'(s_reg) << 16;
                rt_reg  <= '0;
                bit_reg <= XW'(1) << (XW - 2);
                if (s_reg == '0)
                begin
                    r_reg    <= '0;
                    zero_reg <= 1'b1;
                end
            end
            S_ROOT:
            begin
                if (x_reg >= rt_sum)
                begin
                    x_reg  <= x_reg - rt_sum;
                    rt_reg <= (rt_reg >> 1) + bit_reg;
                end
                else
                begin
                    rt_reg <= rt_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            S_DSET:
            begin
                low_reg <= nval[QW-1:0];
                rem_reg <= (DW+1)'(nval[NW-1:QW]);
                ovf_reg <= ((DW+1)'(nval[NW-1:QW]) >= (DW+1)'(dval));
                quo_reg <= '0;
            end
            S_DIV:
            begin
                if (trial >= (DW+1)'(dval))
                begin
                    rem_reg <= trial - (DW+1)'(dval);
                    quo_reg <= {quo_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial;
                    quo_reg <= {quo_reg[QW-2:0], 1'b0};
                end
                low_reg <= {low_reg[QW-2:0], 1'b0};
            end
            S_FIN:
            begin
                case (i_reg)
                    2'd0:    r_reg.x <= m_sel[MW-1] ? -vc : vc;
                    2'd1:    r_reg.y <= m_sel[MW-1] ? -vc : vc;
                    default: r_reg.z <= m_sel[MW-1] ? -vc : vc;
                endcase
            end
            default:
            begin
                zero_reg <= zero_reg;
            end
        endcase
    end

endmodule

/* rtl/core/sts_back.sv */
`timescale 1ns / 1ps
// back end: depth-first triangle stack, midpoint sequencing and output register
// depends on sts_pkg, sts_norm

module sts_back #(
    parameter int MAX_DEPTH = sts_pkg::MAX_DEPTH_DEF,
    parameter int FRAC_BITS = sts_pkg::FRAC_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  sts_pkg::sts_job_t         job,
    output logic                      job_ready,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [sts_pkg::TRI_W-1:0] m_tdata,
    output logic                      m_tlast,
    output logic                      m_tuser
);
    import sts_pkg::*;

    localparam int STACK = 3 * MAX_DEPTH + 1;
    localparam int SPW   = $clog2(STACK + 1);
    localparam int IW    = (STACK > 1) ? $clog2(STACK) : 1;

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_POP  = 3'd1;
    localparam logic [2:0] B_LEAF = 3'd2;
    localparam logic [2:0] B_MID  = 3'd3;
    localparam logic [2:0] B_WAIT = 3'd4;
    localparam logic [2:0] B_PUSH = 3'd5;

    sts_tgl_t           stk_tgl_reg [STACK];
    logic [DEPTH_W-1:0] stk_lvl_reg [STACK];
    logic               stk_flg_reg [STACK];

    logic [2:0]         st_reg;
    logic [SPW-1:0]     sp_reg;
    logic [SPW-1:0]     sp_dec;
    logic [IW-1:0]      rd_idx;
    logic [IW-1:0]      wr_idx;
    sts_tgl_t           cur_reg;
    logic [DEPTH_W-1:0] lvl_reg;
    logic               flg_reg;
    logic               z_reg;
    logic [1:0]         e_reg;
    logic [1:0]         k_reg;
    sts_vertex_t        mid_reg [3];
    sts_vertex_t        np, nq;
    sts_norm_res_t      nres;
    sts_tgl_t           push_tgl;
    logic               out_free;
    logic               ovalid_reg;
    sts_tgl_t           otgl_reg;
    logic               olast_reg;
    logic               ouser_reg;

    assign sp_dec    = sp_reg - 1'b1;
    assign rd_idx    = sp_dec[IW-1:0];
    assign wr_idx    = sp_reg[IW-1:0];
    assign job_ready = (st_reg == B_IDLE);
    assign out_free  = !ovalid_reg || m_tready;

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = tgl_to_bus(otgl_reg);
    assign m_tlast  = olast_reg;
    assign m_tuser  = ouser_reg;

    always_comb
    begin
        case (e_reg)
            2'd0:
            begin
                np = cur_reg.a;
                nq = cur_reg.b;
            end
            2'd1:
            begin
                np = cur_reg.b;
                nq = cur_reg.c;
            end
            default:
            begin
                np = cur_reg.c;
                nq = cur_reg.a;
            end
        endcase
    end

    // children pushed last-first so the pop order is a, b, c, center
    always_comb
    begin
        case (k_reg)
            2'd0:
            begin
                push_tgl.a = mid_reg[0];
                push_tgl.b = mid_reg[1];
                push_tgl.c = mid_reg[2];
            end
            2'd1:
            begin
                push_tgl.a = cur_reg.c;
                push_tgl.b = mid_reg[2];
                push_tgl.c = mid_reg[1];
            end
            2'd2:
            begin
                push_tgl.a = cur_reg.b;
                push_tgl.b = mid_reg[1];
                push_tgl.c = mid_reg[0];
            end
            default:
            begin
                push_tgl.a = cur_reg.a;
                push_tgl.b = mid_reg[0];
                push_tgl.c = mid_reg[2];
            end
        endcase
    end

    sts_norm #(
        .FRAC_BITS(FRAC_BITS)
    ) u_norm (
        .clk  (clk),
        .rst_n(rst_n),
        .start(st_reg == B_MID),
        .p    (np),
        .q    (nq),
        .res  (nres)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= B_IDLE;
            sp_reg     <= '0;
            e_reg      <= 2'd0;
            k_reg      <= 2'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if ((st_reg == B_LEAF) && out_free)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                ovalid_reg <= 1'b0;
            end
            case (st_reg)
                B_IDLE:
                begin
                    if (job.valid)
                    begin
                        sp_reg <= SPW'(1);
                        st_reg <= B_POP;
                    end
                end
                B_POP:
                begin
                    sp_reg <= sp_dec;
                    e_reg  <= 2'd0;
                    st_reg <= (stk_lvl_reg[rd_idx] == '0) ? B_LEAF : B_MID;
                end
                B_LEAF:
                begin
                    if (out_free)
                    begin
                        st_reg <= (sp_reg == '0) ? B_IDLE : B_POP;
                    end
                end
                B_MID:
                begin
                    st_reg <= B_WAIT;
                end
                B_WAIT:
                begin
                    if (nres.done)
                    begin
                        if (e_reg == 2'd2)
                        begin
                            k_reg  <= 2'd0;
                            st_reg <= B_PUSH;
                        end
                        else
                        begin
                            e_reg  <= e_reg + 2'd1;
                            st_reg <= B_MID;
                        end
                    end
                end
                B_PUSH:
                begin
                    sp_reg <= sp_reg + 1'b1;
                    k_reg  <= k_reg + 2'd1;
                    if (k_reg == 2'd3)
                    begin
                        st_reg <= B_POP;
                    end
                end
                default:
                begin
                    st_reg <= B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            B_IDLE:
            begin
                stk_tgl_reg[0] <= job.tgl;
                stk_lvl_reg[0] <= job.depth;
                stk_flg_reg[0] <= 1'b0;
            end
            B_POP:
            begin
                cur_reg <= stk_tgl_reg[rd_idx];
                lvl_reg <= stk_lvl_reg[rd_idx];
                flg_reg <= stk_flg_reg[rd_idx];
                z_reg   <= 1'b0;
            end
            B_LEAF:
            begin
                if (out_free)
                begin
                    otgl_reg  <= cur_reg;
                    olast_reg <= (sp_reg == '0);
                    ouser_reg <= flg_reg;
                end
            end
            B_WAIT:
            begin
                if (nres.done)
                begin
                    mid_reg[e_reg] <= nres.r;
                    z_reg          <= z_reg | nres.zero;
                end
            end
            B_PUSH:
            begin
                stk_tgl_reg[wr_idx] <= push_tgl;
                stk_lvl_reg[wr_idx] <= lvl_reg - 1'b1;
                stk_flg_reg[wr_idx] <= flg_reg | z_reg;
            end
            default:
            begin
                z_reg <= z_reg;
            end
        endcase
    end

endmodule

/* rtl/core/sphere_triangle_subdivider.sv */
`timescale 1ns / 1ps
// top level of the sphere triangle subdivider: front end, job queue, back end
// depends on sts_pkg, sts_front, sts_back
//
//  channel   beat                                            handshake
//  s_*       one triangle ax..cz in tdata                    s_tvalid / s_tready
//  m_*       one leaf ax..cz, tlast last leaf, tuser zero    m_tvalid / m_tready
//  cfg_*     subdivision depth                               cfg_we, no wait
//
//  each internal node runs three normalizations, one after another, on the one shared
//  unit (square root 25 steps, one quotient bit per cycle)
//  an input at depth D has (4^D-1)/3 internal nodes and 4^D leaves
//  the two-entry queue takes new triangles while the back end works
//  reset clears control state only; output stalls hold the back end in place

module sphere_triangle_subdivider #(
    parameter int MAX_DEPTH = sts_pkg::MAX_DEPTH_DEF,
    parameter int FRAC_BITS = sts_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [sts_pkg::DEPTH_W-1:0] cfg_wdata,  // subdivision_depth
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [sts_pkg::TRI_W-1:0]   s_tdata,    // ax, ay, az, bx, by, bz, cx, cy, cz
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [sts_pkg::TRI_W-1:0]   m_tdata,    // out_ax .. out_cz
    output logic                        m_tlast,
    output logic                        m_tuser     // zero_length
);
    import sts_pkg::*;

    sts_job_t job;
    logic     job_ready;

    sts_front #(
        .MAX_DEPTH(MAX_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .job      (job),
        .job_ready(job_ready)
    );

    sts_back #(
        .MAX_DEPTH(MAX_DEPTH),
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .job      (job),
        .job_ready(job_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

/* rtl/core/sts_checker.sv */
`timescale 1ns / 1ps
// port-level checks for the sphere triangle subdivider, bound to the top level
// depends on sts_pkg

module sts_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [sts_pkg::TRI_W-1:0] m_tdata,
    input logic                      m_tlast,
    input logic                      m_tuser
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("output beat changed while stalled");

    a_beat_known: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !$isunknown({m_tdata, m_tlast, m_tuser}))
        else $error("output beat carries unknown bits");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("output valid during reset");

endmodule

bind sphere_triangle_subdivider sts_checker u_sts_checker (.*);
